// File: rtl/bbrb_pkg.sv
// ----------------------------------------------------------------------------
// bbrb_pkg
// Shared types and constants of the broadcast block ring buffer.
// ----------------------------------------------------------------------------
package bbrb_pkg;

  localparam int unsigned SLOTS_DEF      = 4;
  localparam int unsigned MAX_CAP_DEF    = 8;
  localparam int unsigned MAX_BF_DEF     = 64;
  localparam int unsigned MAX_READ_DEF   = 64;

  localparam int unsigned NSTAT = 7;

  localparam logic [6:0] BF_RESET  = 7'd64;
  localparam logic [3:0] CAP_RESET = 4'd8;

  localparam logic [0:0] CFG_BLOCK_FRAMES = 1'b0;
  localparam logic [0:0] CFG_CAPACITY     = 1'b1;

  localparam logic [2:0] STAT_PUB   = 3'd0;
  localparam logic [2:0] STAT_DROP  = 3'd1;
  localparam logic [2:0] STAT_CONS  = 3'd2;
  localparam logic [2:0] STAT_UNDER = 3'd3;
  localparam logic [2:0] STAT_OVER  = 3'd4;
  localparam logic [2:0] STAT_MAXD  = 3'd5;
  localparam logic [2:0] STAT_ACT   = 3'd6;

  typedef enum logic [2:0] {
    OP_ATTACH = 3'd0,
    OP_DETACH = 3'd1,
    OP_WRITE  = 3'd2,
    OP_READ   = 3'd3,
    OP_QUERY  = 3'd4,
    OP_STAT   = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NO_SLOT = 2'd1,
    ST_NOT_PUB = 2'd2,
    ST_FAIL    = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_COPY,
    S_COMMIT,
    S_MCHK,
    S_MRD,
    S_MFIN,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic latch;
    logic exec;
    logic copy_step;
    logic commit_step;
    logic move_start;
    logic move_step;
    logic move_fin;
    logic move_over;
    logic read_under;
    logic emit_start;
    logic emit_step;
  } cmd_t;

  typedef struct packed {
    logic is_write;
    logic write_last;
    logic write_drop;
    logic is_read;
    logic read_bad;
    logic copy_last;
    logic commit_last;
    logic move_last;
    logic emit_last;
    logic enough;
    logic ring_empty;
    logic no_space;
  } sts_t;

endpackage

// File: rtl/broadcast_block_ring_buffer.sv
// ----------------------------------------------------------------------------
// broadcast_block_ring_buffer
// One producer, SLOTS consumers: blocks are copied into every active slot's
// ring with room, read back frame by frame. The receiver cannot stall results:
// each is strobed for exactly one cycle. Every transaction enters an execute
// state after start is taken, and busy is high from that state on. Attach,
// detach, query, statistic, a non-final frame, a dropped block, a rejected read
// and an unknown opcode need only that state, and any result of theirs is
// strobed in the cycle after execute; no new transaction is taken until the
// block is idle again. A final frame that is copied adds copy steps, each
// broadcasting one staging frame to every active ring with room, then commit
// steps, one per slot. A successful read adds a check, the ring reads and a
// finish per block moved from ring to FIFO over the single ring read port, then
// one more check, then an emit step per frame, strobed in the cycle after it.
// ----------------------------------------------------------------------------
module broadcast_block_ring_buffer import bbrb_pkg::*; #(
  parameter int unsigned SLOTS    = SLOTS_DEF,
  parameter int unsigned MAX_CAP  = MAX_CAP_DEF,
  parameter int unsigned MAX_BF   = MAX_BF_DEF,
  parameter int unsigned MAX_READ = MAX_READ_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_opcode,
  input  logic [3:0]  in_slot,
  input  logic [31:0] in_generation,
  input  logic [63:0] in_frame_in,
  input  logic        in_last_frame,
  input  logic [6:0]  in_read_frames,
  input  logic [2:0]  in_stat_select,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [6:0]  cfg_wdata,
  output logic        out_strobe,
  output logic [1:0]  out_status,
  output logic [3:0]  out_slot_out,
  output logic [31:0] out_generation_out,
  output logic [63:0] out_frame_out,
  output logic        out_last_out,
  output logic [31:0] out_value
);

  cmd_t cmd;
  sts_t sts;

  bbrb_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  bbrb_dp #(
    .SLOTS    (SLOTS),
    .MAX_CAP  (MAX_CAP),
    .MAX_BF   (MAX_BF),
    .MAX_READ (MAX_READ)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .in_opcode          (in_opcode),
    .in_slot            (in_slot),
    .in_generation      (in_generation),
    .in_frame_in        (in_frame_in),
    .in_last_frame      (in_last_frame),
    .in_read_frames     (in_read_frames),
    .in_stat_select     (in_stat_select),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .out_strobe         (out_strobe),
    .out_status         (out_status),
    .out_slot_out       (out_slot_out),
    .out_generation_out (out_generation_out),
    .out_frame_out      (out_frame_out),
    .out_last_out       (out_last_out),
    .out_value          (out_value)
  );

endmodule

// File: rtl/bbrb_ctrl.sv
// ----------------------------------------------------------------------------
// bbrb_ctrl
// Sequencer: steps each transaction through execute, block copy, slot commit,
// block move and frame emission.
// ----------------------------------------------------------------------------
module bbrb_ctrl import bbrb_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.latch = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = S_IDLE;
        if (sts.is_write && sts.write_last && !sts.write_drop) begin
          state_nxt = S_COPY;
        end else if (sts.is_read) begin
          if (sts.read_bad) begin
            cmd.read_under = 1'b1;
          end else begin
            state_nxt = S_MCHK;
          end
        end
      end
      S_COPY: begin
        cmd.copy_step = 1'b1;
        if (sts.copy_last) state_nxt = S_COMMIT;
      end
      S_COMMIT: begin
        cmd.commit_step = 1'b1;
        if (sts.commit_last) state_nxt = S_IDLE;
      end
      S_MCHK: begin
        priority if (sts.enough) begin
          cmd.emit_start = 1'b1;
          state_nxt      = S_EMIT;
        end else if (sts.ring_empty) begin
          cmd.read_under = 1'b1;
          state_nxt      = S_IDLE;
        end else if (sts.no_space) begin
          cmd.move_over  = 1'b1;
          cmd.read_under = 1'b1;
          state_nxt      = S_IDLE;
        end else begin
          cmd.move_start = 1'b1;
          state_nxt      = S_MRD;
        end
      end
      S_MRD: begin
        cmd.move_step = 1'b1;
        if (sts.move_last) state_nxt = S_MFIN;
      end
      S_MFIN: begin
        cmd.move_fin = 1'b1;
        state_nxt    = S_MCHK;
      end
      S_EMIT: begin
        cmd.emit_step = 1'b1;
        if (sts.emit_last) state_nxt = S_IDLE;
      end
    endcase
  end

  assign busy = (state_r != S_IDLE);

endmodule

// File: rtl/bbrb_dp.sv
// ----------------------------------------------------------------------------
// bbrb_dp
// Datapath: slot table, staging, per-slot block rings, frame FIFOs,
// statistics counters and the result register.
// ----------------------------------------------------------------------------
module bbrb_dp import bbrb_pkg::*; #(
  parameter int unsigned SLOTS    = SLOTS_DEF,
  parameter int unsigned MAX_CAP  = MAX_CAP_DEF,
  parameter int unsigned MAX_BF   = MAX_BF_DEF,
  parameter int unsigned MAX_READ = MAX_READ_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  cmd_t        cmd,
  output sts_t        sts,
  input  logic [2:0]  in_opcode,
  input  logic [3:0]  in_slot,
  input  logic [31:0] in_generation,
  input  logic [63:0] in_frame_in,
  input  logic        in_last_frame,
  input  logic [6:0]  in_read_frames,
  input  logic [2:0]  in_stat_select,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [6:0]  cfg_wdata,
  output logic        out_strobe,
  output logic [1:0]  out_status,
  output logic [3:0]  out_slot_out,
  output logic [31:0] out_generation_out,
  output logic [63:0] out_frame_out,
  output logic        out_last_out,
  output logic [31:0] out_value
);

  localparam int SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int RE    = MAX_CAP + 1;
  localparam int RW    = $clog2(RE);
  localparam int RAD   = RE * MAX_BF;
  localparam int RAW   = (RAD > 1) ? $clog2(RAD) : 1;
  localparam int FD    = MAX_READ + MAX_BF * MAX_CAP;
  localparam int PW    = (FD > 1) ? $clog2(FD) : 1;
  localparam int CW    = $clog2(FD + 1);
  localparam int BFW   = $clog2(MAX_BF + 1);
  localparam int FILLW = $clog2(MAX_BF + 2);
  localparam int SAW   = (MAX_BF > 1) ? $clog2(MAX_BF) : 1;
  localparam int CAPW  = $clog2(MAX_CAP + 1);
  localparam int IDXA  = (MAX_BF > MAX_READ) ? MAX_BF : MAX_READ;
  localparam int IDXN  = (IDXA > SLOTS) ? IDXA : SLOTS;
  localparam int IW    = (IDXN > 1) ? $clog2(IDXN) : 1;
  localparam int MULW  = BFW + CAPW;
  localparam int QW    = RW + 8;

  function automatic logic [RW-1:0] rnext(input logic [RW-1:0] p, input logic [RW:0] sz);
    logic [RW:0] q;
    q = {1'b0, p} + 1'b1;
    return (q >= sz) ? '0 : q[RW-1:0];
  endfunction

  function automatic logic [RW:0] rdepth(input logic [RW-1:0] rp, input logic [RW-1:0] wp,
                                         input logic [RW:0] sz);
    return (wp >= rp) ? ({1'b0, wp} - {1'b0, rp}) : (sz - {1'b0, rp} + {1'b0, wp});
  endfunction

  function automatic logic [PW-1:0] fnext(input logic [PW-1:0] p);
    return (int'(p) + 1 == FD) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [PW-1:0] fadd(input logic [PW-1:0] h, input logic [CW-1:0] c);
    logic [CW:0] s;
    s = (CW+1)'(h) + (CW+1)'(c);
    if (s >= (CW+1)'(FD)) s = s - (CW+1)'(FD);
    return s[PW-1:0];
  endfunction

  // control state
  logic [6:0]       bf_cfg_r, bf_cfg_nxt;
  logic [3:0]       cap_cfg_r, cap_cfg_nxt;
  logic [SLOTS-1:0] active_r, active_nxt;
  logic [31:0]      gen_r [SLOTS];
  logic [31:0]      gen_nxt [SLOTS];
  logic [RW-1:0]    rd_r [SLOTS];
  logic [RW-1:0]    rd_nxt [SLOTS];
  logic [RW-1:0]    wr_r [SLOTS];
  logic [RW-1:0]    wr_nxt [SLOTS];
  logic [PW-1:0]    head_r [SLOTS];
  logic [PW-1:0]    head_nxt [SLOTS];
  logic [CW-1:0]    cnt_r [SLOTS];
  logic [CW-1:0]    cnt_nxt [SLOTS];
  logic [FILLW-1:0] fill_r, fill_nxt;
  logic [31:0]      next_gen_r, next_gen_nxt;
  logic [31:0]      stat_r [NSTAT];
  logic [31:0]      stat_nxt [NSTAT];
  logic [IW-1:0]    idx_r, idx_nxt;
  logic             pend_copy_r, pend_copy_nxt;
  logic             pend_move_r, pend_move_nxt;
  logic             o_valid_r, o_valid_nxt;

  // payload
  logic [2:0]       op_r;
  logic [3:0]       slot_r;
  logic [31:0]      hgen_r;
  logic [63:0]      frame_r;
  logic             lastf_r;
  logic [6:0]       n_r;
  logic [2:0]       sel_r;
  logic [SLOTS-1:0] mask_r, mask_nxt;
  logic [CW-1:0]    cap_r, cap_nxt;
  logic [PW-1:0]    wp_r, wp_nxt;
  logic [SAW-1:0]   pend_f_r, pend_f_nxt;
  status_t          o_status_r, o_status_nxt;
  logic [3:0]       o_slot_r, o_slot_nxt;
  logic [31:0]      o_gen_r, o_gen_nxt;
  logic             o_last_r, o_last_nxt;
  logic [31:0]      o_value_r, o_value_nxt;
  logic             o_fsel_r, o_fsel_nxt;

  // memories
  logic [63:0] stage_mem [MAX_BF];
  logic [63:0] stage_q;
  logic [63:0] ring_q [SLOTS];
  logic [63:0] fifo_mem [SLOTS][FD];
  logic [63:0] fifo_q;

  // derived
  logic [CAPW-1:0]  ceff;
  logic [RW:0]      rsz;
  logic [BFW-1:0]   bf_eff;
  logic [SW-1:0]    si;
  logic             slot_ok, hok;
  logic [RW-1:0]    rd_s, wr_s;
  logic [PW-1:0]    head_s;
  logic [CW-1:0]    cnt_s;
  logic             found;
  logic [SW-1:0]    fidx;
  logic [SLOTS-1:0] full;
  logic [FILLW-1:0] fill_inc;
  logic             drop;
  logic             stage_we;
  logic [MULW-1:0]  cap_mul;
  logic [QW-1:0]    qprod;
  logic [SW-1:0]    ck;
  logic [RW-1:0]    cnx;
  logic [RW:0]      cdep;

  always_comb begin
    if (cap_cfg_r == 4'd0) begin
      ceff = CAPW'(1);
    end else if (int'(cap_cfg_r) > MAX_CAP) begin
      ceff = CAPW'(MAX_CAP);
    end else begin
      ceff = CAPW'(cap_cfg_r);
    end
    rsz    = (RW+1)'(ceff) + 1'b1;
    bf_eff = (int'(bf_cfg_r) > MAX_BF) ? BFW'(MAX_BF) : BFW'(bf_cfg_r);
    si      = slot_r[SW-1:0];
    slot_ok = int'(slot_r) < SLOTS;
    hok     = slot_ok && active_r[si] && (gen_r[si] == hgen_r);
    rd_s    = rd_r[si];
    wr_s    = wr_r[si];
    head_s  = head_r[si];
    cnt_s   = cnt_r[si];
    found = 1'b0;
    fidx  = '0;
    for (int g = SLOTS - 1; g >= 0; g--) begin
      if (!active_r[g]) begin
        found = 1'b1;
        fidx  = SW'(g);
      end
    end
    for (int g = 0; g < SLOTS; g++) begin
      full[g] = (rnext(wr_r[g], rsz) == rd_r[g]);
    end
    fill_inc = (int'(fill_r) <= MAX_BF) ? fill_r + 1'b1 : fill_r;
    drop     = (int'(fill_inc) != int'(bf_cfg_r)) || (int'(bf_cfg_r) > MAX_BF);
    stage_we = cmd.exec && (op_r == OP_WRITE) && (int'(fill_r) < MAX_BF);
    cap_mul  = MULW'(bf_eff) * MULW'(ceff);
    qprod    = QW'(rdepth(rd_s, wr_s, rsz)) * QW'(bf_cfg_r);
    ck       = idx_r[SW-1:0];
    cnx      = rnext(wr_r[ck], rsz);
    cdep     = rdepth(rd_r[ck], cnx, rsz);
  end

  always_comb begin
    sts.is_write    = (op_r == OP_WRITE);
    sts.write_last  = lastf_r;
    sts.write_drop  = drop;
    sts.is_read     = (op_r == OP_READ);
    sts.read_bad    = (n_r == 7'd0) || (int'(n_r) > MAX_READ) || !hok;
    sts.copy_last   = (int'(idx_r) + 1 == int'(bf_eff));
    sts.commit_last = (int'(idx_r) + 1 == SLOTS);
    sts.move_last   = (int'(idx_r) + 1 == int'(bf_eff));
    sts.emit_last   = (int'(idx_r) + 1 == int'(n_r));
    sts.enough      = (int'(cnt_s) >= int'(n_r));
    sts.ring_empty  = (rd_s == wr_s);
    sts.no_space    = (int'(cnt_s) + int'(bf_eff) > int'(cap_r));
  end

  always_comb begin
    bf_cfg_nxt    = bf_cfg_r;
    cap_cfg_nxt   = cap_cfg_r;
    active_nxt    = active_r;
    gen_nxt       = gen_r;
    rd_nxt        = rd_r;
    wr_nxt        = wr_r;
    head_nxt      = head_r;
    cnt_nxt       = cnt_r;
    fill_nxt      = fill_r;
    next_gen_nxt  = next_gen_r;
    stat_nxt      = stat_r;
    idx_nxt       = idx_r;
    mask_nxt      = mask_r;
    cap_nxt       = cap_r;
    wp_nxt        = wp_r;
    pend_copy_nxt = 1'b0;
    pend_move_nxt = 1'b0;
    pend_f_nxt    = pend_f_r;
    o_valid_nxt   = 1'b0;
    o_status_nxt  = ST_OK;
    o_slot_nxt    = 4'd0;
    o_gen_nxt     = 32'd0;
    o_last_nxt    = 1'b1;
    o_value_nxt   = 32'd0;
    o_fsel_nxt    = 1'b0;

    if (cfg_we) begin
      unique case (cfg_index)
        CFG_BLOCK_FRAMES: bf_cfg_nxt = cfg_wdata;
        CFG_CAPACITY:     cap_cfg_nxt = cfg_wdata[3:0];
      endcase
      for (int g = 0; g < SLOTS; g++) begin
        rd_nxt[g]   = '0;
        wr_nxt[g]   = '0;
        head_nxt[g] = '0;
        cnt_nxt[g]  = '0;
      end
      fill_nxt = '0;
    end

    if (cmd.exec) begin
      case (op_t'(op_r))
        OP_ATTACH: begin
          o_valid_nxt = 1'b1;
          if (found) begin
            rd_nxt[fidx]     = '0;
            wr_nxt[fidx]     = '0;
            head_nxt[fidx]   = '0;
            cnt_nxt[fidx]    = '0;
            gen_nxt[fidx]    = next_gen_r;
            next_gen_nxt     = next_gen_r + 32'd1;
            active_nxt[fidx] = 1'b1;
            stat_nxt[STAT_ACT] = stat_r[STAT_ACT] + 32'd1;
            o_slot_nxt       = 4'(fidx);
            o_gen_nxt        = next_gen_r;
          end else begin
            o_status_nxt = ST_NO_SLOT;
          end
        end
        OP_DETACH: begin
          o_valid_nxt = 1'b1;
          if (hok) begin
            rd_nxt[si]     = '0;
            wr_nxt[si]     = '0;
            head_nxt[si]   = '0;
            cnt_nxt[si]    = '0;
            active_nxt[si] = 1'b0;
            stat_nxt[STAT_ACT] = stat_r[STAT_ACT] - 32'd1;
          end else begin
            o_status_nxt = ST_FAIL;
          end
        end
        OP_WRITE: begin
          fill_nxt = fill_inc;
          if (lastf_r) begin
            fill_nxt = '0;
            if (drop) begin
              stat_nxt[STAT_DROP] = stat_r[STAT_DROP] + 32'd1;
              o_valid_nxt  = 1'b1;
              o_status_nxt = ST_NOT_PUB;
            end else begin
              mask_nxt = active_r & ~full;
              idx_nxt  = '0;
            end
          end
        end
        OP_READ: begin
          cap_nxt = CW'(MAX_READ) + CW'(cap_mul);
        end
        OP_QUERY: begin
          o_valid_nxt = 1'b1;
          if (hok) begin
            o_value_nxt = 32'(cnt_s) + 32'(qprod);
          end else begin
            o_status_nxt = ST_FAIL;
          end
        end
        OP_STAT: begin
          o_valid_nxt = 1'b1;
          if (int'(sel_r) < NSTAT) begin
            o_value_nxt = stat_r[sel_r];
          end else begin
            o_status_nxt = ST_FAIL;
          end
        end
        default: begin
          o_valid_nxt  = 1'b1;
          o_status_nxt = ST_FAIL;
        end
      endcase
    end

    if (cmd.copy_step) begin
      pend_copy_nxt = 1'b1;
      pend_f_nxt    = idx_r[SAW-1:0];
      idx_nxt       = sts.copy_last ? '0 : idx_r + 1'b1;
    end

    if (cmd.commit_step) begin
      if (mask_r[ck]) begin
        wr_nxt[ck] = cnx;
        stat_nxt[STAT_PUB] = stat_r[STAT_PUB] + 32'd1;
        if (32'(cdep) > stat_r[STAT_MAXD]) stat_nxt[STAT_MAXD] = 32'(cdep);
      end else if (active_r[ck]) begin
        stat_nxt[STAT_OVER] = stat_r[STAT_OVER] + 32'd1;
        stat_nxt[STAT_DROP] = stat_r[STAT_DROP] + 32'd1;
      end
      idx_nxt = idx_r + 1'b1;
      if (sts.commit_last) begin
        o_valid_nxt  = 1'b1;
        o_status_nxt = (|mask_r) ? ST_OK : ST_NOT_PUB;
      end
    end

    if (cmd.move_start) begin
      wp_nxt  = fadd(head_s, cnt_s);
      idx_nxt = '0;
    end

    if (cmd.move_step) begin
      pend_move_nxt = 1'b1;
      idx_nxt       = idx_r + 1'b1;
    end

    if (pend_move_r) wp_nxt = fnext(wp_r);

    if (cmd.move_fin) begin
      rd_nxt[si]  = rnext(rd_s, rsz);
      cnt_nxt[si] = cnt_s + CW'(bf_eff);
      stat_nxt[STAT_CONS] = stat_r[STAT_CONS] + 32'd1;
    end

    if (cmd.move_over) stat_nxt[STAT_OVER] = stat_r[STAT_OVER] + 32'd1;

    if (cmd.read_under) begin
      stat_nxt[STAT_UNDER] = stat_r[STAT_UNDER] + 32'd1;
      o_valid_nxt  = 1'b1;
      o_status_nxt = ST_FAIL;
    end

    if (cmd.emit_start) idx_nxt = '0;

    if (cmd.emit_step) begin
      head_nxt[si] = fnext(head_s);
      cnt_nxt[si]  = cnt_s - 1'b1;
      idx_nxt      = idx_r + 1'b1;
      o_valid_nxt  = 1'b1;
      o_last_nxt   = sts.emit_last;
      o_fsel_nxt   = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bf_cfg_r    <= BF_RESET;
      cap_cfg_r   <= CAP_RESET;
      active_r    <= '0;
      for (int g = 0; g < SLOTS; g++) begin
        gen_r[g]  <= '0;
        rd_r[g]   <= '0;
        wr_r[g]   <= '0;
        head_r[g] <= '0;
        cnt_r[g]  <= '0;
      end
      for (int k = 0; k < NSTAT; k++) stat_r[k] <= '0;
      fill_r      <= '0;
      next_gen_r  <= '0;
      idx_r       <= '0;
      pend_copy_r <= 1'b0;
      pend_move_r <= 1'b0;
      o_valid_r   <= 1'b0;
    end else begin
      bf_cfg_r    <= bf_cfg_nxt;
      cap_cfg_r   <= cap_cfg_nxt;
      active_r    <= active_nxt;
      gen_r       <= gen_nxt;
      rd_r        <= rd_nxt;
      wr_r        <= wr_nxt;
      head_r      <= head_nxt;
      cnt_r       <= cnt_nxt;
      stat_r      <= stat_nxt;
      fill_r      <= fill_nxt;
      next_gen_r  <= next_gen_nxt;
      idx_r       <= idx_nxt;
      pend_copy_r <= pend_copy_nxt;
      pend_move_r <= pend_move_nxt;
      o_valid_r   <= o_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_r    <= in_opcode;
      slot_r  <= in_slot;
      hgen_r  <= in_generation;
      frame_r <= in_frame_in;
      lastf_r <= in_last_frame;
      n_r     <= in_read_frames;
      sel_r   <= in_stat_select;
    end
    mask_r     <= mask_nxt;
    cap_r      <= cap_nxt;
    wp_r       <= wp_nxt;
    pend_f_r   <= pend_f_nxt;
    o_status_r <= o_status_nxt;
    o_slot_r   <= o_slot_nxt;
    o_gen_r    <= o_gen_nxt;
    o_last_r   <= o_last_nxt;
    o_value_r  <= o_value_nxt;
    o_fsel_r   <= o_fsel_nxt;
  end

  always_ff @(posedge clk) begin
    if (stage_we) stage_mem[fill_r[SAW-1:0]] <= frame_r;
    if (cmd.copy_step) stage_q <= stage_mem[idx_r[SAW-1:0]];
  end

  for (genvar g = 0; g < SLOTS; g++) begin : g_ring
    logic [63:0]    ring_mem [RAD];
    logic [RAW-1:0] ring_wa, ring_ra;

    assign ring_wa = RAW'(int'(wr_r[g]) * MAX_BF + int'(pend_f_r));
    assign ring_ra = RAW'(int'(rd_r[g]) * MAX_BF + int'(idx_r));

    always_ff @(posedge clk) begin
      if (pend_copy_r && mask_r[g]) ring_mem[ring_wa] <= stage_q;
      if (cmd.move_step) ring_q[g] <= ring_mem[ring_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (pend_move_r) fifo_mem[si][wp_r] <= ring_q[si];
    if (cmd.emit_step) fifo_q <= fifo_mem[si][head_s];
  end

  assign out_strobe         = o_valid_r;
  assign out_status         = o_status_r;
  assign out_slot_out       = o_slot_r;
  assign out_generation_out = o_gen_r;
  assign out_frame_out      = o_fsel_r ? fifo_q : 64'd0;
  assign out_last_out       = o_last_r;
  assign out_value          = o_value_r;

endmodule

// File: rtl/bbrb_chk.sv
// ----------------------------------------------------------------------------
// bbrb_chk
// Port-level checks of the broadcast block ring buffer, bound to the top.
// ----------------------------------------------------------------------------
module bbrb_chk import bbrb_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        out_strobe,
  input logic [1:0]  out_status,
  input logic [3:0]  out_slot_out,
  input logic [63:0] out_frame_out,
  input logic        out_last_out
);

  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_strobe && !busy)
    else $error("strobe or busy after reset");

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted transaction did not raise busy");

  a_fail_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && (out_status != ST_OK) |-> out_last_out && (out_frame_out == 64'd0))
    else $error("failed transaction not a single clean result");

  a_slot_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && (out_slot_out != 4'd0) |-> (out_status == ST_OK) && out_last_out)
    else $error("slot granted outside a successful attach");

endmodule

bind broadcast_block_ring_buffer bbrb_chk u_bbrb_chk (
  .clk           (clk),
  .rst_n         (rst_n),
  .start         (start),
  .busy          (busy),
  .out_strobe    (out_strobe),
  .out_status    (out_status),
  .out_slot_out  (out_slot_out),
  .out_frame_out (out_frame_out),
  .out_last_out  (out_last_out)
);

// File: bench/broadcast_block_ring_buffer_tb.sv
// ----------------------------------------------------------------------------
// broadcast_block_ring_buffer_tb
// Self-checking bench for the broadcast block ring buffer. A predictor keeps
// its own copy of slots, rings, FIFOs and counters and queues the expected
// results of every command. A clocked driver presents commands from a queue
// and a clocked monitor checks every strobed result in order. Several block
// sizes and ring capacities are run, the out-of-range ones among them.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module broadcast_block_ring_buffer_tb;
  import bbrb_pkg::*;

  localparam int unsigned NSLOT = 4;
  localparam int unsigned CAPMAX = 8;
  localparam int unsigned BFMAX = 64;
  localparam int unsigned RDMAX = 64;
  localparam int unsigned FDEPTH = RDMAX + BFMAX * CAPMAX;
  localparam longint unsigned CYCLE_LIMIT = 3000000;

  typedef struct {
    logic [2:0]  op;
    logic [3:0]  slot;
    logic [31:0] gen;
    logic [63:0] frame;
    logic        last;
    logic [6:0]  nrd;
    logic [2:0]  sel;
  } cmd_item_t;

  typedef struct {
    logic [1:0]  status;
    logic [3:0]  slot;
    logic [31:0] gen;
    logic [63:0] frame;
    logic        last;
    logic [31:0] value;
  } resp_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [2:0]  in_opcode = '0;
  logic [3:0]  in_slot = '0;
  logic [31:0] in_generation = '0;
  logic [63:0] in_frame_in = '0;
  logic        in_last_frame = 1'b0;
  logic [6:0]  in_read_frames = '0;
  logic [2:0]  in_stat_select = '0;
  logic        cfg_we = 1'b0;
  logic [0:0]  cfg_index = CFG_BLOCK_FRAMES;
  logic [6:0]  cfg_wdata = '0;
  logic        out_strobe;
  logic [1:0]  out_status;
  logic [3:0]  out_slot_out;
  logic [31:0] out_generation_out;
  logic [63:0] out_frame_out;
  logic        out_last_out;
  logic [31:0] out_value;

  broadcast_block_ring_buffer dut (.*);

  always #5 clk = ~clk;

  // predictor state
  logic [6:0]  m_bf;
  logic [3:0]  m_cap;
  logic        m_active [NSLOT];
  logic [31:0] m_gen [NSLOT];
  int unsigned m_rd [NSLOT];
  int unsigned m_wr [NSLOT];
  logic [63:0] m_ring [NSLOT][CAPMAX+1][BFMAX];
  logic [63:0] m_fifo [NSLOT][FDEPTH];
  int unsigned m_head [NSLOT];
  int unsigned m_cnt [NSLOT];
  int unsigned m_fill;
  logic [31:0] m_next_gen;
  logic [31:0] m_stat [NSTAT];
  logic [63:0] m_stage [BFMAX];

  cmd_item_t   pending_cmds [$];
  resp_t       expected_resps [$];
  int unsigned errors = 0;
  int unsigned n_cmds = 0;
  int unsigned n_resps = 0;
  int unsigned n_cfg = 0;
  int unsigned idle_pct = 0;
  longint unsigned cycles = 0;

  function automatic int unsigned ring_slots();
    int unsigned c;
    c = m_cap;
    if (c == 0) c = 1;
    if (c > CAPMAX) c = CAPMAX;
    return c + 1;
  endfunction

  function automatic int unsigned ring_next(int unsigned p);
    return (p + 1 >= ring_slots()) ? 0 : p + 1;
  endfunction

  function automatic int unsigned ring_fill(int unsigned rd, int unsigned wr);
    return wr >= rd ? wr - rd : ring_slots() - rd + wr;
  endfunction

  function automatic void clear_slot(int unsigned s);
    m_rd[s] = 0;
    m_wr[s] = 0;
    m_head[s] = 0;
    m_cnt[s] = 0;
  endfunction

  function automatic bit handle_ok(logic [3:0] s, logic [31:0] g);
    return s < NSLOT && m_active[s] && m_gen[s] == g;
  endfunction

  function automatic void expect_resp(logic [1:0] st, logic [3:0] sl, logic [31:0] g,
                                      logic [63:0] fr, logic lst, logic [31:0] v);
    resp_t r;
    r.status = st; r.slot = sl; r.gen = g; r.frame = fr; r.last = lst; r.value = v;
    expected_resps.insert(expected_resps.size(), r);
  endfunction

  function automatic void model_reset();
    m_bf = BF_RESET;
    m_cap = CAP_RESET;
    for (int s = 0; s < NSLOT; s++) begin
      m_active[s] = 1'b0;
      m_gen[s] = '0;
      clear_slot(s);
    end
    for (int i = 0; i < NSTAT; i++) m_stat[i] = '0;
    m_fill = 0;
    m_next_gen = '0;
  endfunction

  function automatic void model_write(cmd_item_t c);
    int unsigned len;
    bit pub;
    pub = 1'b0;
    if (m_fill < BFMAX) m_stage[m_fill] = c.frame;
    if (m_fill <= BFMAX) m_fill++;
    if (!c.last) return;
    len = m_fill;
    m_fill = 0;
    if (len != m_bf || m_bf > BFMAX) begin
      m_stat[STAT_DROP]++;
      expect_resp(ST_NOT_PUB, '0, '0, '0, 1'b1, '0);
      return;
    end
    for (int s = 0; s < NSLOT; s++) begin
      if (!m_active[s]) continue;
      if (ring_next(m_wr[s]) == m_rd[s]) begin
        m_stat[STAT_OVER]++;
        m_stat[STAT_DROP]++;
        continue;
      end
      for (int f = 0; f < len; f++) m_ring[s][m_wr[s]][f] = m_stage[f];
      m_wr[s] = ring_next(m_wr[s]);
      if (ring_fill(m_rd[s], m_wr[s]) > m_stat[STAT_MAXD])
        m_stat[STAT_MAXD] = ring_fill(m_rd[s], m_wr[s]);
      m_stat[STAT_PUB]++;
      pub = 1'b1;
    end
    expect_resp(pub ? ST_OK : ST_NOT_PUB, '0, '0, '0, 1'b1, '0);
  endfunction

  function automatic void model_read(cmd_item_t c);
    int unsigned s, n, bf, room;
    s = c.slot;
    n = c.nrd;
    if (n == 0 || n > RDMAX || !handle_ok(c.slot, c.gen)) begin
      m_stat[STAT_UNDER]++;
      expect_resp(ST_FAIL, '0, '0, '0, 1'b1, '0);
      return;
    end
    bf = m_bf > BFMAX ? BFMAX : m_bf;
    room = RDMAX + bf * (ring_slots() - 1);
    while (m_cnt[s] < n) begin
      if (m_rd[s] == m_wr[s]) break;
      if (room - m_cnt[s] < bf) begin
        m_stat[STAT_OVER]++;
        break;
      end
      for (int i = 0; i < bf; i++) begin
        m_fifo[s][(m_head[s] + m_cnt[s]) % FDEPTH] = m_ring[s][m_rd[s]][i];
        m_cnt[s]++;
      end
      m_rd[s] = ring_next(m_rd[s]);
      m_stat[STAT_CONS]++;
    end
    if (m_cnt[s] < n) begin
      m_stat[STAT_UNDER]++;
      expect_resp(ST_FAIL, '0, '0, '0, 1'b1, '0);
      return;
    end
    for (int i = 0; i < n; i++) begin
      expect_resp(ST_OK, '0, '0, m_fifo[s][m_head[s]], i + 1 == n, '0);
      m_head[s] = (m_head[s] + 1) % FDEPTH;
      m_cnt[s]--;
    end
  endfunction

  function automatic void model_cmd(cmd_item_t c);
    logic [31:0] v;
    case (c.op)
      OP_ATTACH: begin
        for (int i = 0; i < NSLOT; i++) begin
          if (m_active[i]) continue;
          clear_slot(i);
          m_gen[i] = m_next_gen;
          m_next_gen++;
          m_active[i] = 1'b1;
          m_stat[STAT_ACT]++;
          expect_resp(ST_OK, 4'(i), m_gen[i], '0, 1'b1, '0);
          return;
        end
        expect_resp(ST_NO_SLOT, '0, '0, '0, 1'b1, '0);
      end
      OP_DETACH: begin
        if (!handle_ok(c.slot, c.gen)) begin
          expect_resp(ST_FAIL, '0, '0, '0, 1'b1, '0);
        end else begin
          clear_slot(c.slot);
          m_active[c.slot] = 1'b0;
          m_stat[STAT_ACT]--;
          expect_resp(ST_OK, '0, '0, '0, 1'b1, '0);
        end
      end
      OP_WRITE: model_write(c);
      OP_READ: model_read(c);
      OP_QUERY: begin
        if (!handle_ok(c.slot, c.gen)) begin
          expect_resp(ST_FAIL, '0, '0, '0, 1'b1, '0);
        end else begin
          v = m_cnt[c.slot] + ring_fill(m_rd[c.slot], m_wr[c.slot]) * 32'(m_bf);
          expect_resp(ST_OK, '0, '0, '0, 1'b1, v);
        end
      end
      OP_STAT: begin
        if (c.sel >= NSTAT) expect_resp(ST_FAIL, '0, '0, '0, 1'b1, '0);
        else expect_resp(ST_OK, '0, '0, '0, 1'b1, m_stat[c.sel]);
      end
      default: expect_resp(ST_FAIL, '0, '0, '0, 1'b1, '0);
    endcase
  endfunction

  function automatic cmd_item_t noise_cmd();
    cmd_item_t c;
    c.op = 3'($urandom_range(0, 7));
    c.slot = 4'($urandom);
    c.gen = $urandom;
    c.frame = {$urandom, $urandom};
    c.last = 1'($urandom);
    c.nrd = 7'($urandom);
    c.sel = 3'($urandom);
    return c;
  endfunction

  task automatic issue(cmd_item_t c);
    model_cmd(c);
    pending_cmds.insert(pending_cmds.size(), c);
    n_cmds++;
  endtask

  task automatic issue_op(logic [2:0] op, logic [3:0] s, logic [31:0] g,
                          logic [6:0] n, logic [2:0] sel);
    cmd_item_t c;
    c = noise_cmd();
    c.op = op; c.slot = s; c.gen = g; c.nrd = n; c.sel = sel; c.last = 1'b0;
    issue(c);
  endtask

  task automatic issue_block(int unsigned len);
    cmd_item_t c;
    for (int i = 0; i < len; i++) begin
      c = noise_cmd();
      c.op = OP_WRITE;
      c.last = (i + 1 == len);
      issue(c);
    end
  endtask

  task automatic issue_mixed(int unsigned quota);
    int unsigned target, r, s, avail, bfe;
    target = n_cmds + quota;
    while (n_cmds < target) begin
      r = $urandom_range(0, 99);
      s = $urandom_range(0, NSLOT - 1);
      bfe = (m_bf >= 1 && m_bf <= BFMAX) ? m_bf : $urandom_range(1, 6);
      if (r < 8) begin
        issue(noise_cmd());
      end else if (r < 16) begin
        issue_op(OP_ATTACH, '0, '0, '0, '0);
      end else if (r < 45) begin
        if ($urandom_range(0, 9) == 0) issue_block($urandom_range(1, bfe + 1));
        else if ($urandom_range(0, 60) == 0) issue_block(BFMAX + 2);
        else issue_block(bfe);
      end else if (r < 75) begin
        avail = m_cnt[s] + ring_fill(m_rd[s], m_wr[s]) * bfe;
        if (!m_active[s] || avail == 0 || $urandom_range(0, 9) == 0)
          issue_op(OP_READ, 4'(s), m_gen[s], 7'($urandom_range(1, RDMAX)), '0);
        else
          issue_op(OP_READ, 4'(s), m_gen[s],
                   7'($urandom_range(1, avail > RDMAX ? RDMAX : avail)), '0);
      end else if (r < 84) begin
        issue_op(OP_QUERY, 4'(s), m_gen[s], '0, '0);
      end else if (r < 93) begin
        issue_op(OP_STAT, '0, '0, '0, 3'($urandom_range(0, 7)));
      end else begin
        issue_op(OP_DETACH, 4'(s), m_gen[s], '0, '0);
      end
    end
  endtask

  task automatic drain();
    wait (pending_cmds.size() == 0 && expected_resps.size() == 0);
    repeat (12) @(posedge clk);
    while (busy || start) @(posedge clk);
  endtask

  task automatic set_reg(logic [0:0] idx, logic [6:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_BLOCK_FRAMES) m_bf = v;
    else m_cap = v[3:0];
    for (int s = 0; s < NSLOT; s++) clear_slot(s);
    m_fill = 0;
    n_cfg++;
  endtask

  // driver
  always @(posedge clk) begin
    cmd_item_t c;
    if (rst_n) begin
      if (!start || !busy) begin
        if (pending_cmds.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
          c = pending_cmds.pop_front();
          in_opcode <= c.op;
          in_slot <= c.slot;
          in_generation <= c.gen;
          in_frame_in <= c.frame;
          in_last_frame <= c.last;
          in_read_frames <= c.nrd;
          in_stat_select <= c.sel;
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    resp_t e;
    if (rst_n && out_strobe) begin
      if (expected_resps.size() == 0) begin
        $error("unexpected transaction: status %0d frame %h", out_status, out_frame_out);
        errors++;
      end else begin
        e = expected_resps.pop_front();
        n_resps++;
        if (out_status !== e.status) begin
          $error("status: expected %0d, got %0d", e.status, out_status); errors++;
        end
        if (out_slot_out !== e.slot) begin
          $error("slot_out: expected %0d, got %0d", e.slot, out_slot_out); errors++;
        end
        if (out_generation_out !== e.gen) begin
          $error("generation_out: expected %h, got %h", e.gen, out_generation_out);
          errors++;
        end
        if (out_frame_out !== e.frame) begin
          $error("frame_out: expected %h, got %h", e.frame, out_frame_out); errors++;
        end
        if (out_last_out !== e.last) begin
          $error("last_out: expected %0d, got %0d", e.last, out_last_out); errors++;
        end
        if (out_value !== e.value) begin
          $error("value: expected %0d, got %0d", e.value, out_value); errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    model_reset();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed: small blocks, single-block rings
    set_reg(CFG_BLOCK_FRAMES, 7'd2);
    set_reg(CFG_CAPACITY, 7'd1);
    for (int i = 0; i < 5; i++) issue_op(OP_ATTACH, '0, '0, '0, '0);
    issue_block(2);
    issue_block(2);
    issue_block(1);
    issue_op(OP_QUERY, 4'd0, m_gen[0], '0, '0);
    issue_op(OP_READ, 4'd0, m_gen[0], 7'd2, '0);
    issue_op(OP_READ, 4'd1, m_gen[1], 7'd0, '0);
    issue_op(OP_READ, 4'd1, m_gen[1], 7'd127, '0);
    issue_op(OP_READ, 4'd1, ~m_gen[1], 7'd1, '0);
    issue_op(OP_READ, 4'd0, m_gen[0], 7'd1, '0);
    issue_op(OP_QUERY, 4'd15, '1, '0, '0);
    issue_op(OP_STAT, '0, '0, '0, 3'd7);
    issue_op(3'(OP_STAT) + 3'd1, '0, '0, '0, '0);
    issue_op(3'(OP_STAT) + 3'd2, '0, '0, '0, '0);
    issue_op(OP_DETACH, 4'd2, ~m_gen[2], '0, '0);
    issue_op(OP_DETACH, 4'd2, m_gen[2], '0, '0);
    for (int i = 0; i < NSTAT; i++) issue_op(OP_STAT, '0, '0, '0, 3'(i));
    drain();

    idle_pct = 34;
    set_reg(CFG_BLOCK_FRAMES, 7'd4);
    set_reg(CFG_CAPACITY, 7'd3);
    issue_mixed(70);
    drain();
    set_reg(CFG_BLOCK_FRAMES, 7'd1);
    set_reg(CFG_CAPACITY, 7'd0);
    issue_mixed(50);
    drain();

    idle_pct = 62;
    set_reg(CFG_BLOCK_FRAMES, 7'd0);
    set_reg(CFG_CAPACITY, 7'd15);
    issue_mixed(30);
    drain();
    set_reg(CFG_BLOCK_FRAMES, 7'd127);
    issue_mixed(20);
    drain();
    set_reg(CFG_BLOCK_FRAMES, 7'd3);
    set_reg(CFG_CAPACITY, 7'd8);
    issue_mixed(60);
    drain();

    idle_pct = 0;
    set_reg(CFG_BLOCK_FRAMES, 7'd64);
    set_reg(CFG_CAPACITY, 7'd2);
    issue_mixed(100);
    drain();
    set_reg(CFG_BLOCK_FRAMES, 7'd5);
    set_reg(CFG_CAPACITY, 7'd1);
    issue_mixed(60);
    drain();

    $display("run: %0d commands, %0d results checked, %0d register writes",
             n_cmds, n_resps, n_cfg);
    $display("run: block sizes 0..127 and ring capacities 0..15, sender gaps 34/62/0 pct");
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
